// ===== sv/mcr_pkg.sv =====
// ---------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Widths, types and codes shared by the rasterizer and its channel interfaces.
// ---------------------------------------------------------------------------
package mcr_pkg;

	localparam int COORD_WIDTH = 12;
	localparam int RAD_WIDTH   = COORD_WIDTH - 1;
	localparam int PIX_WIDTH   = COORD_WIDTH + 2;
	localparam int DEC_WIDTH   = COORD_WIDTH + 2;

	// function codes of an input transaction
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// eight mirror pixels per octant point
	localparam int          MIRROR_COUNT = 8;
	localparam int          IDX_WIDTH    = $clog2(MIRROR_COUNT);
	localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(MIRROR_COUNT - 1);

	typedef logic        [COORD_WIDTH-1:0] coord_t;
	typedef logic        [RAD_WIDTH-1:0]   rad_t;
	typedef logic signed [PIX_WIDTH-1:0]   pix_t;
	typedef logic signed [DEC_WIDTH-1:0]   dec_t;
	typedef logic        [IDX_WIDTH-1:0]   idx_t;

endpackage

// ===== sv/mcr_in_if.sv =====
// ---------------------------------------------------------------------------
// Rasterizer command channel
// Valid/ready channel carrying start and step commands.
// ---------------------------------------------------------------------------
interface mcr_in_if;

	logic            valid;
	logic            ready;
	logic            func;
	mcr_pkg::coord_t center_x;
	mcr_pkg::coord_t center_y;
	mcr_pkg::rad_t   radius;

	modport source (output valid, output func, output center_x, output center_y,
		output radius, input ready);
	modport sink (input valid, input func, input center_x, input center_y,
		input radius, output ready);

endinterface

// ===== sv/mcr_out_if.sv =====
// ---------------------------------------------------------------------------
// Rasterizer pixel channel
// Valid/ready channel carrying plotted pixels and arc-complete reports.
// ---------------------------------------------------------------------------
interface mcr_out_if;

	logic          valid;
	logic          ready;
	mcr_pkg::pix_t pixel_x;
	mcr_pkg::pix_t pixel_y;
	logic          pixel_valid;
	logic          last;
	logic          done_res;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_valid,
		output last, output done_res, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_valid,
		input last, input done_res, output ready);

endinterface

// ===== sv/midpoint_circle_rasterizer_unit.sv =====
// ---------------------------------------------------------------------------
// Midpoint circle rasterizer
// Octant stepper with eight-way mirroring onto a single pixel channel.
// ---------------------------------------------------------------------------
// An accepted command is captured into the emitter snapshot, and its first result
// is then loaded from there into the output register, from which it can be taken.
// A start or a stepping command gives eight results, one per cycle from the mirror
// counter while the pixel side takes them; a done report gives one.
// While the emitter is busy, a new command is taken only together with the last
// result of the one before, as set by the single output port. Reset clears the
// circle state and empties the emitter and output register.
module midpoint_circle_rasterizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	mcr_in_if.sink     item,
	mcr_out_if.source  result
);

	// circle state
	mcr_pkg::coord_t cx_q, cy_q;
	mcr_pkg::rad_t   ox_q, oy_q;
	mcr_pkg::dec_t   dec_q;
	logic            active_q;

	// emitter snapshot
	mcr_pkg::coord_t cx_s1, cy_s1;
	mcr_pkg::rad_t   ox_s1, oy_s1;
	logic            done_s1;
	logic            busy_s1;
	mcr_pkg::idx_t   idx_s1;

	// output register
	logic            out_valid_q;
	mcr_pkg::pix_t   px_q, py_q;
	logic            pvalid_q, last_q, done_q;

	logic            produce, finishing, accept;
	logic            step_done;
	mcr_pkg::rad_t   ox_n, oy_n;
	mcr_pkg::dec_t   dec_n;
	logic signed [mcr_pkg::DEC_WIDTH:0] p_ext, x_ext, y_ext;
	mcr_pkg::rad_t   a_off, b_off;
	mcr_pkg::pix_t   px_n, py_n;
	logic            last_n;

	assign produce   = busy_s1 && (!out_valid_q || result.ready);
	assign last_n    = done_s1 || (idx_s1 == mcr_pkg::LAST_IDX);
	assign finishing = produce && last_n;
	assign item.ready = !busy_s1 || finishing;
	assign accept    = item.valid && item.ready;

	// next octant point
	always_comb begin
		step_done = !active_q || (ox_q >= oy_q);
		ox_n  = ox_q + mcr_pkg::RAD_WIDTH'(1);
		oy_n  = oy_q;
		p_ext = (mcr_pkg::DEC_WIDTH + 1)'(dec_q);
		x_ext = (mcr_pkg::DEC_WIDTH + 1)'(ox_n);
		y_ext = '0;
		if (dec_q < 0) begin
			p_ext = (mcr_pkg::DEC_WIDTH + 1)'(p_ext + (x_ext <<< 1) + 1);
		end else begin
			oy_n  = oy_q - mcr_pkg::RAD_WIDTH'(1);
			y_ext = (mcr_pkg::DEC_WIDTH + 1)'(oy_n);
			p_ext = (mcr_pkg::DEC_WIDTH + 1)'(p_ext + ((x_ext - y_ext) <<< 1) + 1);
		end
		dec_n = p_ext[mcr_pkg::DEC_WIDTH-1:0];
	end

	// mirror select: bit 2 swaps x/y, bit 0 negates first offset, bit 1 the second
	always_comb begin
		a_off = idx_s1[2] ? oy_s1 : ox_s1;
		b_off = idx_s1[2] ? ox_s1 : oy_s1;
		if (idx_s1[0])
			px_n = mcr_pkg::PIX_WIDTH'(cx_s1) - mcr_pkg::PIX_WIDTH'(a_off);
		else
			px_n = mcr_pkg::PIX_WIDTH'(cx_s1) + mcr_pkg::PIX_WIDTH'(a_off);
		if (idx_s1[1])
			py_n = mcr_pkg::PIX_WIDTH'(cy_s1) - mcr_pkg::PIX_WIDTH'(b_off);
		else
			py_n = mcr_pkg::PIX_WIDTH'(cy_s1) + mcr_pkg::PIX_WIDTH'(b_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			case (item.func)
				mcr_pkg::FUNC_START: begin
					cx_q     <= item.center_x;
					cy_q     <= item.center_y;
					ox_q     <= '0;
					oy_q     <= item.radius;
					dec_q    <= mcr_pkg::dec_t'(1) - mcr_pkg::DEC_WIDTH'(item.radius);
					active_q <= 1'b1;
				end
				mcr_pkg::FUNC_STEP: begin
					if (step_done) begin
						active_q <= 1'b0;
					end else begin
						ox_q  <= ox_n;
						oy_q  <= oy_n;
						dec_q <= dec_n;
					end
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

	// snapshot for the emitter
	always_ff @(posedge clk) begin
		if (accept) begin
			if (item.func == mcr_pkg::FUNC_START) begin
				cx_s1   <= item.center_x;
				cy_s1   <= item.center_y;
				ox_s1   <= '0;
				oy_s1   <= item.radius;
				done_s1 <= 1'b0;
			end else begin
				cx_s1   <= cx_q;
				cy_s1   <= cy_q;
				ox_s1   <= ox_n;
				oy_s1   <= oy_n;
				done_s1 <= step_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) begin
				out_valid_q <= 1'b1;
				idx_s1      <= idx_s1 + mcr_pkg::IDX_WIDTH'(1);
				if (last_n)
					busy_s1 <= 1'b0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_s1 <= 1'b1;
				idx_s1  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			px_q     <= done_s1 ? '0 : px_n;
			py_q     <= done_s1 ? '0 : py_n;
			pvalid_q <= !done_s1;
			last_q   <= last_n;
			done_q   <= done_s1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pixel_x     = px_q;
	assign result.pixel_y     = py_q;
	assign result.pixel_valid = pvalid_q;
	assign result.last        = last_q;
	assign result.done_res    = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |-> result.last && !result.pixel_valid)
		else $error("done report not a single non-pixel result");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> busy_s1 && idx_s1 == '0)
		else $error("accepted transaction did not load the emitter");

	a_done_first: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && done_s1 |-> idx_s1 == '0)
		else $error("done report emitter advanced past one result");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && !last_n |-> !item.ready)
		else $error("command taken while mirror pixels remain");

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// Midpoint circle rasterizer testbench
// Sends start and step commands, rebuilds the octant walk alongside the block
// and checks every pixel and arc-complete report in order. Both channels idle
// at random. The pixel side holds off once for a long stretch, and the
// command side drains the block twice before going on.
// ---------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_AT      = 1000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		logic            func;
		mcr_pkg::coord_t cx;
		mcr_pkg::coord_t cy;
		mcr_pkg::rad_t   r;
		bit              settle;	// wait for every pixel to come out before sending
	} cmd_t;

	typedef struct {
		mcr_pkg::pix_t px;
		mcr_pkg::pix_t py;
		logic          pv;
		logic          last;
		logic          done;
	} pixel_t;

	logic clk;
	logic arst_n;

	mcr_in_if  cmd_if ();
	mcr_out_if pix_if ();

	midpoint_circle_rasterizer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_if),
		.result (pix_if)
	);

	cmd_t   pending[$];
	pixel_t pixel_q[$];
	int     fails = 0;
	int     cycles = 0;

	// circle state as the block should hold it
	mcr_pkg::coord_t arc_cx = '0;
	mcr_pkg::coord_t arc_cy = '0;
	mcr_pkg::rad_t   arc_x = '0;
	mcr_pkg::rad_t   arc_y = '0;
	mcr_pkg::dec_t   arc_dec = '0;
	bit              arc_on = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_cmd(logic f, mcr_pkg::coord_t x, mcr_pkg::coord_t y,
		mcr_pkg::rad_t r);
		cmd_t c;
		c = '{f, x, y, r, 1'b0};
		pending.push_back(c);
	endfunction

	// eight mirror images of the current octant point
	function automatic void mirror_point();
		mcr_pkg::pix_t cx, cy, x, y;
		mcr_pkg::pix_t xs[mcr_pkg::MIRROR_COUNT];
		mcr_pkg::pix_t ys[mcr_pkg::MIRROR_COUNT];
		pixel_t        p;
		cx = mcr_pkg::pix_t'(arc_cx);
		cy = mcr_pkg::pix_t'(arc_cy);
		x  = mcr_pkg::pix_t'(arc_x);
		y  = mcr_pkg::pix_t'(arc_y);
		xs = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
		ys = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
		for (int i = 0; i < mcr_pkg::MIRROR_COUNT; i++) begin
			p = '{xs[i], ys[i], 1'b1, (i == mcr_pkg::MIRROR_COUNT - 1), 1'b0};
			pixel_q.push_back(p);
		end
	endfunction

	function automatic void trace_arc(cmd_t c);
		mcr_pkg::dec_t p, xd, yd;
		pixel_t        d;
		if (c.func == mcr_pkg::FUNC_START) begin
			arc_cx  = c.cx;
			arc_cy  = c.cy;
			arc_x   = '0;
			arc_y   = c.r;
			arc_dec = mcr_pkg::dec_t'(1 - int'(c.r));
			arc_on  = 1'b1;
			mirror_point();
		end else if (!arc_on || arc_x >= arc_y) begin
			arc_on = 1'b0;
			d = '{'0, '0, 1'b0, 1'b1, 1'b1};
			pixel_q.push_back(d);
		end else begin
			p     = arc_dec;
			arc_x = arc_x + 1'b1;
			xd    = mcr_pkg::dec_t'(arc_x);
			if (p < 0) begin
				p = mcr_pkg::dec_t'(p + 2 * xd + 1);
			end else begin
				arc_y = arc_y - 1'b1;
				yd    = mcr_pkg::dec_t'(arc_y);
				p     = mcr_pkg::dec_t'(p + 2 * (xd - yd) + 1);
			end
			arc_dec = p;
			mirror_point();
		end
	endfunction

	// command driver
	int gap_left = 0;
	int send_calm = 0;
	bit send_quiet = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		cmd_t nxt;
		cmd_t seen;
		if (!arst_n) begin
			cmd_if.valid    <= 1'b0;
			cmd_if.func     <= mcr_pkg::FUNC_START;
			cmd_if.center_x <= '0;
			cmd_if.center_y <= '0;
			cmd_if.radius   <= '0;
			gap_left = 0;
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				seen = '{cmd_if.func, cmd_if.center_x, cmd_if.center_y, cmd_if.radius, 1'b0};
				trace_arc(seen);
				if (send_calm == 0) begin
					send_calm  = $urandom_range(10, 40);
					send_quiet = ($urandom_range(0, 2) == 0);
				end
				send_calm--;
				gap_left = send_quiet ? 0 : idle_len();
			end
			if (!(cmd_if.valid && !cmd_if.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_if.valid <= 1'b0;
				end else if (pending.size() > 0 &&
						!(pending[0].settle && pixel_q.size() > 0)) begin
					nxt = pending.pop_front();
					cmd_if.valid    <= 1'b1;
					cmd_if.func     <= nxt.func;
					cmd_if.center_x <= nxt.cx;
					cmd_if.center_y <= nxt.cy;
					cmd_if.radius   <= nxt.r;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// pixel side back-pressure
	int taken = 0;
	int stall_left = 0;
	int recv_window = 0;
	bit recv_quiet = 1'b0;
	bit held_long = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.ready <= 1'b0;
		end else begin
			if (pix_if.valid && pix_if.ready)
				taken++;
			if (recv_window == 0) begin
				recv_window = $urandom_range(20, 150);
				recv_quiet  = ($urandom_range(0, 2) == 0);
			end
			recv_window--;
			if (!held_long && taken >= HOLD_AT) begin
				held_long  = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left == 0 && !recv_quiet && $urandom_range(0, 3) == 0)
				stall_left = idle_len();
			if (stall_left > 0) begin
				stall_left--;
				pix_if.ready <= 1'b0;
			end else begin
				pix_if.ready <= 1'b1;
			end
		end
	end

	// pixel checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			if (pixel_q.size() == 0) begin
				$error("result transaction with nothing expected: x %0d y %0d",
					pix_if.pixel_x, pix_if.pixel_y);
				fails++;
			end else begin
				want = pixel_q.pop_front();
				if (pix_if.pixel_x !== want.px) begin
					$error("pixel_x: expected %0d, got %0d", want.px, pix_if.pixel_x);
					fails++;
				end
				if (pix_if.pixel_y !== want.py) begin
					$error("pixel_y: expected %0d, got %0d", want.py, pix_if.pixel_y);
					fails++;
				end
				if (pix_if.pixel_valid !== want.pv) begin
					$error("pixel_valid: expected %0b, got %0b", want.pv, pix_if.pixel_valid);
					fails++;
				end
				if (pix_if.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, pix_if.last);
					fails++;
				end
				if (pix_if.done_res !== want.done) begin
					$error("done_res: expected %0b, got %0b", want.done, pix_if.done_res);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int            n_dir;
		int            sel;
		int            steps;
		int            roll;
		mcr_pkg::rad_t r;
		arst_n = 1'b0;

		// directed: idle step, zero radius, extreme centres and radii,
		// restart mid-arc, alternating bit patterns
		queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_STEP, '1, '1, '1);
		queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, '1, '1, '1);
		repeat (3) queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, '0, '0, '1);
		queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, '1, '0, 11'd1);
		repeat (3) queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, '0, '1, 11'd5);
		queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, 12'haaa, 12'h555, 11'h555);
		queue_cmd(mcr_pkg::FUNC_STEP, '0, '0, '0);
		queue_cmd(mcr_pkg::FUNC_START, 12'h555, 12'haaa, 11'h2aa);
		repeat (2) queue_cmd(mcr_pkg::FUNC_STEP, 12'h555, 12'haaa, 11'h2aa);
		n_dir = pending.size();

		while (pending.size() < n_dir + RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				queue_cmd(mcr_pkg::FUNC_STEP, mcr_pkg::coord_t'($urandom),
					mcr_pkg::coord_t'($urandom), mcr_pkg::rad_t'($urandom));
			end else if (sel == 1) begin
				queue_cmd(mcr_pkg::FUNC_START, mcr_pkg::coord_t'($urandom),
					mcr_pkg::coord_t'($urandom), mcr_pkg::rad_t'($urandom));
			end else begin
				// well-formed arc: start, then steps until done or abandoned
				roll = $urandom_range(0, 19);
				if (roll == 0)
					r = mcr_pkg::rad_t'($urandom_range(0, 2047));
				else if (roll == 1)
					r = '0;
				else
					r = mcr_pkg::rad_t'($urandom_range(1, 40));
				queue_cmd(mcr_pkg::FUNC_START, mcr_pkg::coord_t'($urandom),
					mcr_pkg::coord_t'($urandom), r);
				if (r <= 40)
					steps = int'(r) * 3 / 4 + $urandom_range(0, 2);
				else
					steps = $urandom_range(1, 12);
				if ($urandom_range(0, 7) == 0)
					steps = $urandom_range(0, steps);
				repeat (steps)
					queue_cmd(mcr_pkg::FUNC_STEP, mcr_pkg::coord_t'($urandom),
						mcr_pkg::coord_t'($urandom), mcr_pkg::rad_t'($urandom));
			end
		end
		pending[n_dir].settle = 1'b1;
		pending[n_dir + 180].settle = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || cmd_if.valid) @(negedge clk);
		while (pixel_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fails == 0 && pixel_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
